[src/spectrum_bin_calibration_macros.svh]
// ----------------------------------------------------------------------------
// spectrum_bin_calibration assertion macros
// Shared assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BIN_CALIBRATION_MACROS_SVH
`define SPECTRUM_BIN_CALIBRATION_MACROS_SVH

// Same-cycle implication
`define SBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// sbc_pkg
// Types, constants and calibration tables of the spectrum bin calibration.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int FFT_SIZE    = 4096;
  localparam int MAX_FREQ_HZ = 400;

  // Cutoff frequency in Q20.8 Hz
  localparam logic [27:0] CUTOFF_Q8 = 28'(MAX_FREQ_HZ * 256);

  // 2 * 1e4 (factor units) * 256 (Q8.8 sensitivity), shifted by 16 later
  localparam logic [22:0] SENS_SCALE = 23'd5120000;

  localparam int CAL_LEN = 21;
  localparam int X_W     = 12;
  localparam int K_W     = 10;
  localparam int F10_W   = 21;
  localparam int D_W     = 19;
  localparam int P_W     = K_W + D_W;

  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 27;
  localparam int DIV_QUO_W = 32;
  localparam int DIV_HI_W  = DIV_NUM_W - DIV_QUO_W;

  // Channel codes
  localparam logic [2:0] CH_A = 3'd0;
  localparam logic [2:0] CH_B = 3'd1;
  localparam logic [2:0] CH_D = 3'd2;
  localparam logic [2:0] CH_E = 3'd3;
  localparam logic [2:0] CH_F = 3'd4;

  // Register indexes
  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_THRESH,
    REG_BIN_WIDTH,
    REG_SENS_A,
    REG_SENS_B,
    REG_SENS_D,
    REG_SENS_E,
    REG_SENS_F
  } reg_idx_t;

  typedef struct packed {
    logic              enable;
    logic [23:0]       thresh;
    logic [15:0]       bin_width;
    logic [4:0][15:0]  sens;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic [11:0]        bin;
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               scale;
    logic               cut;
  } ctx_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic [11:0]        bin;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               supp;
  } res_t;

  // Breakpoints in tenths of Hz; unused entries are zero
  localparam logic [X_W-1:0] CAL_X [5][CAL_LEN] = '{
    '{12'd0, 12'd50, 12'd63, 12'd80, 12'd100, 12'd125, 12'd160, 12'd200, 12'd250,
      12'd310, 12'd400, 12'd500, 12'd630, 12'd800, 12'd1000, 12'd1250, 12'd1600,
      12'd2000, 12'd2500, 12'd3150, 12'd4000},
    '{12'd0, 12'd50, 12'd63, 12'd80, 12'd100, 12'd125, 12'd160, 12'd200, 12'd250,
      12'd310, 12'd400, 12'd500, 12'd630, 12'd800, 12'd1000, 12'd1250, 12'd1600,
      12'd2000, 12'd2500, 12'd3150, 12'd4000},
    '{12'd0, 12'd100, 12'd125, 12'd160, 12'd200, 12'd250, 12'd310, 12'd400, 12'd500,
      12'd630, 12'd800, 12'd1000, 12'd1250, 12'd1600, 12'd3150, 12'd4000,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{12'd0, 12'd100, 12'd125, 12'd160, 12'd200, 12'd250, 12'd310, 12'd400, 12'd500,
      12'd630, 12'd800, 12'd1000, 12'd1250, 12'd1600, 12'd2000, 12'd2500, 12'd3150,
      12'd4000, 12'd0, 12'd0, 12'd0},
    '{12'd0, 12'd160, 12'd200, 12'd250, 12'd310, 12'd400, 12'd500, 12'd630, 12'd800,
      12'd1000, 12'd1250, 12'd1600, 12'd2000, 12'd2500, 12'd3150, 12'd4000,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0}
  };

  // Calibration factors in units of 1e-4
  localparam logic [K_W-1:0] CAL_K [5][CAL_LEN] = '{
    '{10'd333, 10'd333, 10'd328, 10'd330, 10'd329, 10'd327, 10'd328, 10'd327, 10'd329,
      10'd331, 10'd335, 10'd340, 10'd340, 10'd352, 10'd367, 10'd392, 10'd435,
      10'd458, 10'd481, 10'd427, 10'd431},
    '{10'd520, 10'd520, 10'd513, 10'd514, 10'd517, 10'd519, 10'd517, 10'd520, 10'd522,
      10'd523, 10'd525, 10'd527, 10'd535, 10'd545, 10'd552, 10'd567, 10'd588,
      10'd605, 10'd626, 10'd492, 10'd331},
    '{10'd231, 10'd231, 10'd211, 10'd217, 10'd225, 10'd214, 10'd214, 10'd223, 10'd228,
      10'd179, 10'd183, 10'd181, 10'd171, 10'd189, 10'd137, 10'd149,
      10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd199, 10'd199, 10'd218, 10'd222, 10'd219, 10'd219, 10'd212, 10'd212, 10'd224,
      10'd217, 10'd189, 10'd200, 10'd202, 10'd225, 10'd190, 10'd221, 10'd288,
      10'd333, 10'd0, 10'd0, 10'd0},
    '{10'd220, 10'd220, 10'd221, 10'd208, 10'd210, 10'd212, 10'd211, 10'd213, 10'd218,
      10'd159, 10'd173, 10'd168, 10'd170, 10'd170, 10'd117, 10'd102,
      10'd0, 10'd0, 10'd0, 10'd0, 10'd0}
  };

  // Number of used breakpoints per channel
  localparam logic [4:0] CAL_N [5] = '{5'd21, 5'd21, 5'd16, 5'd18, 5'd16};

endpackage

[src/sbc_if.sv]
// ----------------------------------------------------------------------------
// sbc_if
// Valid/ready channels for input bins and calibrated results.
// ----------------------------------------------------------------------------
interface sbc_bin_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel;
  logic [11:0]        bin_index;
  logic signed [23:0] re_in;
  logic signed [23:0] im_in;

  modport source (output valid, channel, bin_index, re_in, im_in, input ready);
  modport sink (input valid, channel, bin_index, re_in, im_in, output ready);
endinterface

interface sbc_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel_out;
  logic [11:0]        bin_out;
  logic signed [31:0] re_out;
  logic signed [31:0] im_out;
  logic               suppressed;

  modport source (output valid, channel_out, bin_out, re_out, im_out, suppressed,
                  input ready);
  modport sink (input valid, channel_out, bin_out, re_out, im_out, suppressed,
                output ready);
endinterface

[src/spectrum_bin_calibration.sv]
// ----------------------------------------------------------------------------
// spectrum_bin_calibration
// Calibrates complex FFT bins per channel with table-interpolated gain,
// frequency cutoff and noise threshold.
// ----------------------------------------------------------------------------
// The block takes one bin per clock while ready is high and returns one
// result per bin, in order. The path has 5 stages of frequency and interpolation
// work, a 32-stage divider for the calibration factor, a 32-stage divider for
// the gain, 4 stages of gain, saturation and noise test, and the output
// register. A two-entry output buffer lets the pipeline keep running while a
// result waits; when both entries are full, ready drops until one is taken.
// Registers sit on an APB port at byte address 4*i and should be written
// only while no bins are in flight.
`include "spectrum_bin_calibration_macros.svh"

module spectrum_bin_calibration (
  input  logic        clk,
  input  logic        rst,
  sbc_bin_if.sink     spec_in,
  sbc_res_if.source   spec_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbc_pkg::*;

  cfg_t cfg;
  logic en;
  ctx_t in_ctx;

  logic                 i_valid, d1_valid, d2_valid, b_valid;
  logic [DIV_NUM_W-1:0] i_num, g_num;
  logic [DIV_DEN_W-1:0] i_den, g_den;
  ctx_t                 i_ctx, d1_ctx, d2_ctx;
  logic [DIV_QUO_W-1:0] kq, gq;
  logic [15:0]          sens_sel;
  logic [38:0]          gain_num;
  res_t                 b_res;

  logic out_valid, skid_valid, arrive, take;
  res_t out_data, skid_data;

  reg_idx_t reg_idx;

  // Register writes
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= 1'b1;
      cfg.thresh    <= '0;
      cfg.bin_width <= 16'd256;
      cfg.sens      <= {5{16'd256}};
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_ENABLE:    cfg.enable    <= pwdata[0];
        REG_THRESH:    cfg.thresh    <= pwdata[23:0];
        REG_BIN_WIDTH: cfg.bin_width <= pwdata[15:0];
        REG_SENS_A:    cfg.sens[0]   <= pwdata[15:0];
        REG_SENS_B:    cfg.sens[1]   <= pwdata[15:0];
        REG_SENS_D:    cfg.sens[2]   <= pwdata[15:0];
        REG_SENS_E:    cfg.sens[3]   <= pwdata[15:0];
        REG_SENS_F:    cfg.sens[4]   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_ENABLE:    prdata = {31'b0, cfg.enable};
      REG_THRESH:    prdata = {8'b0, cfg.thresh};
      REG_BIN_WIDTH: prdata = {16'b0, cfg.bin_width};
      REG_SENS_A:    prdata = {16'b0, cfg.sens[0]};
      REG_SENS_B:    prdata = {16'b0, cfg.sens[1]};
      REG_SENS_D:    prdata = {16'b0, cfg.sens[2]};
      REG_SENS_E:    prdata = {16'b0, cfg.sens[3]};
      REG_SENS_F:    prdata = {16'b0, cfg.sens[4]};
      default:       prdata = '0;
    endcase
  end

  // Pipeline advances while the skid entry is free
  assign en            = !skid_valid;
  assign spec_in.ready = en;

  always_comb begin
    in_ctx.channel = spec_in.channel;
    in_ctx.bin     = spec_in.bin_index;
    in_ctx.re      = spec_in.re_in;
    in_ctx.im      = spec_in.im_in;
    in_ctx.scale   = 1'b0;
    in_ctx.cut     = 1'b0;
  end

  sbc_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (spec_in.valid),
    .in_ctx    (in_ctx),
    .out_valid (i_valid),
    .out_num   (i_num),
    .out_den   (i_den),
    .out_ctx   (i_ctx)
  );

  // Calibration factor in Q16
  sbc_div u_div_factor (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (i_valid),
    .in_num    (i_num),
    .in_den    (i_den),
    .in_ctx    (i_ctx),
    .out_valid (d1_valid),
    .out_quo   (kq),
    .out_ctx   (d1_ctx)
  );

  // Gain dividend: sensitivity times the fixed scale, in Q16
  assign sens_sel = (d1_ctx.channel <= CH_F) ? cfg.sens[d1_ctx.channel] : 16'd0;
  assign gain_num = 39'(sens_sel) * 39'(SENS_SCALE);
  assign g_num    = DIV_NUM_W'({gain_num, 16'b0});
  assign g_den    = DIV_DEN_W'(kq);

  sbc_div u_div_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_valid),
    .in_num    (g_num),
    .in_den    (g_den),
    .in_ctx    (d1_ctx),
    .out_valid (d2_valid),
    .out_quo   (gq),
    .out_ctx   (d2_ctx)
  );

  sbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (d2_valid),
    .in_gain   (gq),
    .in_ctx    (d2_ctx),
    .out_valid (b_valid),
    .out_res   (b_res)
  );

  // Output register with one skid entry
  assign arrive = b_valid && en;
  assign take   = out_valid && spec_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (arrive) begin
        out_data <= b_res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (arrive) begin
      if (!out_valid) begin
        out_data  <= b_res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= b_res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign spec_out.valid       = out_valid;
  assign spec_out.channel_out = out_data.channel;
  assign spec_out.bin_out     = out_data.bin;
  assign spec_out.re_out      = out_data.re;
  assign spec_out.im_out      = out_data.im;
  assign spec_out.suppressed  = out_data.supp;

  `SBC_ASSERT_IMP(a_skid_needs_out, skid_valid, out_valid, "skid entry held without output")
  `SBC_ASSERT_NXT(a_stall_fills_skid, out_valid && !spec_out.ready && arrive, skid_valid, "stalled arrival lost")
  `SBC_ASSERT_IMP(a_supp_zero, out_valid && out_data.supp, (out_data.re == 32'sd0) && (out_data.im == 32'sd0), "suppressed bin not zero")

endmodule

[src/sbc_interp.sv]
// ----------------------------------------------------------------------------
// sbc_interp
// Bin frequency, cutoff decision, table segment search and the
// interpolation products; emits the dividend and divisor of the factor.
// ----------------------------------------------------------------------------
module sbc_interp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  sbc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  sbc_pkg::ctx_t                 in_ctx,
  output logic                          out_valid,
  output logic [sbc_pkg::DIV_NUM_W-1:0] out_num,
  output logic [sbc_pkg::DIV_DEN_W-1:0] out_den,
  output sbc_pkg::ctx_t                 out_ctx
);
  import sbc_pkg::*;

  logic v1, v2, v3, v4, v5;
  ctx_t c1, c2, c3, c4, c5;
  ctx_t c2_next;

  logic [27:0]      f;
  logic             on, in_band;
  logic [16:0]      f2;
  logic [F10_W-1:0] f10, f10_3;
  logic [2:0]       ci3, ci4;
  logic [4:0]       j, j3;
  logic             found, found3;
  logic [X_W-1:0]   x0, x1, dx, dx4, dx5;
  logic [D_W-1:0]   d, s, sd4, d4;
  logic [K_W-1:0]   k0_4, k1_4;
  logic [P_W-1:0]   p0, p1;
  logic [P_W:0]     m_sum;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Bin frequency in Q20.8 Hz and cutoff decision
  always_comb begin
    f       = 28'(c1.bin) * 28'(cfg.bin_width);
    in_band = (f <= CUTOFF_Q8) && (int'(c1.bin) < FFT_SIZE);
    on      = cfg.enable && (c1.bin != 12'd0) && (c1.channel <= CH_F);
  end

  // Tag the bin for scaling or cutoff
  always_comb begin
    c2_next       = c1;
    c2_next.scale = on && in_band;
    c2_next.cut   = on && !in_band && ((c1.channel == CH_A) || (c1.channel == CH_B));
  end

  // Search the segment holding the frequency
  always_comb begin
    f10   = F10_W'({f2, 3'b000}) + F10_W'({f2, 1'b0});
    ci3   = (c2.channel <= CH_F) ? c2.channel : CH_A;
    j     = 5'd0;
    found = 1'b0;
    for (int m = 0; m < CAL_LEN - 1; m++) begin
      if (((5'(m) + 5'd1) < CAL_N[ci3]) &&
          (f10 >= F10_W'({CAL_X[ci3][m], 8'b0})) &&
          (f10 < F10_W'({CAL_X[ci3][m + 1], 8'b0}))) begin
        j     = 5'(m);
        found = 1'b1;
      end
    end
  end

  // Offset into the segment and segment span
  always_comb begin
    ci4 = (c3.channel <= CH_F) ? c3.channel : CH_A;
    x0  = CAL_X[ci4][j3];
    x1  = CAL_X[ci4][5'(j3 + 5'd1)];
    dx  = x1 - x0;
    s   = D_W'({dx, 8'b0});
    d   = found3 ? D_W'(f10_3 - F10_W'({x0, 8'b0})) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= in_ctx;

      c2 <= c2_next;
      f2 <= f[16:0];

      c3     <= c2;
      f10_3  <= f10;
      j3     <= j;
      found3 <= found;

      c4   <= c3;
      sd4  <= s - d;
      d4   <= d;
      dx4  <= dx;
      k0_4 <= CAL_K[ci4][j3];
      k1_4 <= CAL_K[ci4][5'(j3 + 5'd1)];

      c5  <= c4;
      dx5 <= dx4;
      p0  <= P_W'(k0_4) * P_W'(sd4);
      p1  <= P_W'(k1_4) * P_W'(d4);
    end
  end

  // Dividend is the weighted sum scaled by 256, divisor the span in tenths of Hz
  assign m_sum     = {1'b0, p0} + {1'b0, p1};
  assign out_valid = v5;
  assign out_num   = DIV_NUM_W'({m_sum, 8'b0});
  assign out_den   = DIV_DEN_W'(dx5);
  assign out_ctx   = c5;

endmodule

[src/sbc_div.sv]
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined restoring divider, one quotient bit per stage. The dividend's
// upper part must be below the divisor so that the quotient fits.
// ----------------------------------------------------------------------------
module sbc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [sbc_pkg::DIV_NUM_W-1:0] in_num,
  input  logic [sbc_pkg::DIV_DEN_W-1:0] in_den,
  input  sbc_pkg::ctx_t                 in_ctx,
  output logic                          out_valid,
  output logic [sbc_pkg::DIV_QUO_W-1:0] out_quo,
  output sbc_pkg::ctx_t                 out_ctx
);
  import sbc_pkg::*;

  logic                 vld_s [DIV_QUO_W+1];
  logic [DIV_DEN_W-1:0] rem_s [DIV_QUO_W+1];
  logic [DIV_QUO_W-1:0] lo_s  [DIV_QUO_W+1];
  logic [DIV_DEN_W-1:0] den_s [DIV_QUO_W+1];
  ctx_t                 ctx_s [DIV_QUO_W+1];

  assign vld_s[0] = in_valid;
  assign rem_s[0] = DIV_DEN_W'(in_num[DIV_NUM_W-1:DIV_QUO_W]);
  assign lo_s[0]  = in_num[DIV_QUO_W-1:0];
  assign den_s[0] = in_den;
  assign ctx_s[0] = in_ctx;

  for (genvar i = 0; i < DIV_QUO_W; i++) begin : g_step
    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] diff;
    logic               ge;

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_s[i], lo_s[i][DIV_QUO_W-1]};
    assign diff  = trial - {1'b0, den_s[i]};
    assign ge    = trial >= {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        lo_s[i+1]  <= {lo_s[i][DIV_QUO_W-2:0], ge};
        den_s[i+1] <= den_s[i];
        ctx_s[i+1] <= ctx_s[i];
      end
    end
  end

  assign out_valid = vld_s[DIV_QUO_W];
  assign out_quo   = lo_s[DIV_QUO_W];
  assign out_ctx   = ctx_s[DIV_QUO_W];

endmodule

[src/sbc_back.sv]
// ----------------------------------------------------------------------------
// sbc_back
// Gain multiply with rounding and saturation, cutoff selection and the
// noise threshold test on channels A and B.
// ----------------------------------------------------------------------------
module sbc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  sbc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic [sbc_pkg::DIV_QUO_W-1:0] in_gain,
  input  sbc_pkg::ctx_t                 in_ctx,
  output logic                          out_valid,
  output sbc_pkg::res_t                 out_res
);
  import sbc_pkg::*;

  // Round half away from zero on the magnitude, then saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic [55:0] prod,
                                                   input logic neg);
    logic [56:0] sum;
    logic [40:0] q;
    sum = {1'b0, prod} + 57'd32768;
    q   = sum[56:16];
    if (neg) begin
      return (q > 41'h0080000000) ? 32'sh80000000 : 32'(~q + 41'd1);
    end
    return (q > 41'h007FFFFFFF) ? 32'sh7FFFFFFF : 32'(q);
  endfunction

  function automatic logic [31:0] sre_mag(input logic signed [31:0] v);
    return v[31] ? 32'(~v + 32'sd1) : 32'(v);
  endfunction

  logic v7, v8, v9, v10;
  ctx_t c7, c8;

  logic [23:0]        mag_re, mag_im;
  logic [55:0]        pr, pi;
  logic               known8, ab9;
  logic signed [31:0] re8, im8, gre, gim;
  logic signed [31:0] sre, sim;
  logic               supp8, supp9;
  logic signed [31:0] re_hold, im_hold;
  logic               supp_h;
  logic [31:0]        mre, mim;
  logic [63:0]        sq_re, sq_im;
  logic [47:0]        t2;
  logic signed [31:0] re9, im9;
  logic [2:0]         ch9;
  logic [11:0]        bin9;
  logic [64:0]        pow;
  logic               low;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v7  <= in_valid;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  // Magnitudes of the input parts
  assign mag_re = in_ctx.re[23] ? 24'(~in_ctx.re + 24'd1) : 24'(in_ctx.re);
  assign mag_im = in_ctx.im[23] ? 24'(~in_ctx.im + 24'd1) : 24'(in_ctx.im);

  // Select scaled, zeroed or unchanged parts
  always_comb begin
    known8 = c7.channel <= CH_F;
    gre    = round_sat(pr, c7.re[23]);
    gim    = round_sat(pi, c7.im[23]);
    sre    = {{8{c7.re[23]}}, c7.re};
    sim    = {{8{c7.im[23]}}, c7.im};
    if (known8 && c7.scale) begin
      re8 = gre;
      im8 = gim;
    end else if (known8 && c7.cut) begin
      re8 = '0;
      im8 = '0;
    end else begin
      re8 = sre;
      im8 = sim;
    end
    supp8 = known8 && c7.cut;
  end

  // Magnitudes of the selected parts
  assign mre = sre_mag(re_hold);
  assign mim = sre_mag(im_hold);

  always_ff @(posedge clk) begin
    if (en) begin
      c7 <= in_ctx;
      pr <= 56'(mag_re) * 56'(in_gain);
      pi <= 56'(mag_im) * 56'(in_gain);

      c8      <= c7;
      re_hold <= re8;
      im_hold <= im8;
      supp_h  <= supp8;

      sq_re <= 64'(mre) * 64'(mre);
      sq_im <= 64'(mim) * 64'(mim);
      t2    <= 48'(cfg.thresh) * 48'(cfg.thresh);
      re9   <= re_hold;
      im9   <= im_hold;
      supp9 <= supp_h;
      ch9   <= c8.channel;
      bin9  <= c8.bin;
      ab9   <= (c8.channel == CH_A) || (c8.channel == CH_B);
    end
  end

  // Noise test on the saturated values
  assign pow = {1'b0, sq_re} + {1'b0, sq_im};
  assign low = ab9 && (pow < 65'(t2));

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.channel <= ch9;
      out_res.bin     <= bin9;
      out_res.re      <= low ? 32'sd0 : re9;
      out_res.im      <= low ? 32'sd0 : im9;
      out_res.supp    <= supp9 || low;
    end
  end

  assign out_valid = v10;

endmodule

[test/spectrum_bin_calibration_checker.sv]
// ----------------------------------------------------------------------------
// spectrum_bin_calibration_checker
// Mirrors the register writes and predicts each calibrated bin from the bins
// that enter. Compares every result transfer field by field with the oldest
// prediction and counts the failures.
// ----------------------------------------------------------------------------
module spectrum_bin_calibration_checker (
  input  logic        clk,
  input  logic        rst,
  sbc_bin_if          bin_ch,
  sbc_res_if          res_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          outstanding
);
  import sbc_pkg::*;

  // Frequency breakpoints (tenths of Hz) and factors (1e-4) per channel
  localparam int SEG_N [5] = '{21, 21, 16, 18, 16};
  localparam int BRK_X [5][21] = '{
    '{0, 50, 63, 80, 100, 125, 160, 200, 250, 310, 400, 500, 630, 800, 1000, 1250,
      1600, 2000, 2500, 3150, 4000},
    '{0, 50, 63, 80, 100, 125, 160, 200, 250, 310, 400, 500, 630, 800, 1000, 1250,
      1600, 2000, 2500, 3150, 4000},
    '{0, 100, 125, 160, 200, 250, 310, 400, 500, 630, 800, 1000, 1250, 1600, 3150,
      4000, 0, 0, 0, 0, 0},
    '{0, 100, 125, 160, 200, 250, 310, 400, 500, 630, 800, 1000, 1250, 1600, 2000,
      2500, 3150, 4000, 0, 0, 0},
    '{0, 160, 200, 250, 310, 400, 500, 630, 800, 1000, 1250, 1600, 2000, 2500, 3150,
      4000, 0, 0, 0, 0, 0}
  };
  localparam int BRK_K [5][21] = '{
    '{333, 333, 328, 330, 329, 327, 328, 327, 329, 331, 335, 340, 340, 352, 367, 392,
      435, 458, 481, 427, 431},
    '{520, 520, 513, 514, 517, 519, 517, 520, 522, 523, 525, 527, 535, 545, 552, 567,
      588, 605, 626, 492, 331},
    '{231, 231, 211, 217, 225, 214, 214, 223, 228, 179, 183, 181, 171, 189, 137, 149,
      0, 0, 0, 0, 0},
    '{199, 199, 218, 222, 219, 219, 212, 212, 224, 217, 189, 200, 202, 225, 190, 221,
      288, 333, 0, 0, 0},
    '{220, 220, 221, 208, 210, 212, 211, 213, 218, 159, 173, 168, 170, 170, 117, 102,
      0, 0, 0, 0, 0}
  };

  logic             corr_on;
  logic [23:0]      thresh;
  logic [15:0]      spacing;
  logic [4:0][15:0] sens;
  res_t             calib_q[$];

  // Scale one part by the Q16 gain, round half away from zero, saturate
  function automatic longint scale_part(longint v, longint unsigned gq);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = (mag * gq + 64'd32768) >> 16;
    if (v < 0) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  // Interpolated calibration factor, Q16 of 1e-4 units
  function automatic longint unsigned cal_factor(int ch, longint unsigned f10);
    int j;
    bit found;
    longint unsigned d, s;
    j = 0;
    found = 0;
    for (int m = 0; m < SEG_N[ch] - 1; m++) begin
      if (f10 >= 256 * BRK_X[ch][m] && f10 < 256 * BRK_X[ch][m+1]) begin
        j = m;
        found = 1;
      end
    end
    if (!found) return longint'(BRK_K[ch][0]) << 16;
    d = f10 - 256 * BRK_X[ch][j];
    s = 256 * (BRK_X[ch][j+1] - BRK_X[ch][j]);
    return ((BRK_K[ch][j] * (s - d) + BRK_K[ch][j+1] * d) << 16) / s;
  endfunction

  function automatic res_t calibrate_bin(logic [2:0] ch, logic [11:0] idx,
                                         logic signed [23:0] re,
                                         logic signed [23:0] im);
    res_t r;
    longint sr, si;
    longint unsigned f, gq, ar, ai, t;
    bit is_ab;
    sr = re;
    si = im;
    r.supp = 1'b0;
    if (ch <= CH_F) begin
      is_ab = (ch == CH_A) || (ch == CH_B);
      if (corr_on && idx != 0) begin
        f = 64'(idx) * 64'(spacing);
        if (f <= MAX_FREQ_HZ * 256) begin
          gq = (64'(sens[ch]) * 64'd335544320000) / cal_factor(ch, f * 10);
          sr = scale_part(sr, gq);
          si = scale_part(si, gq);
        end else if (is_ab) begin
          sr = 0;
          si = 0;
          r.supp = 1'b1;
        end
      end
      if (is_ab) begin
        ar = (sr < 0) ? longint'(-sr) : longint'(sr);
        ai = (si < 0) ? longint'(-si) : longint'(si);
        t = thresh;
        if (ar * ar + ai * ai < t * t) begin
          sr = 0;
          si = 0;
          r.supp = 1'b1;
        end
      end
    end
    r.channel = ch;
    r.bin = idx;
    r.re = sr[31:0];
    r.im = si[31:0];
    return r;
  endfunction

  // Mirror registers, predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      corr_on <= 1'b1;
      thresh <= '0;
      spacing <= 16'd256;
      for (int c = 0; c < 5; c++) sens[c] <= 16'd256;
      calib_q.delete();
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_ENABLE:    corr_on <= pwdata[0];
          REG_THRESH:    thresh <= pwdata[23:0];
          REG_BIN_WIDTH: spacing <= pwdata[15:0];
          REG_SENS_A:    sens[0] <= pwdata[15:0];
          REG_SENS_B:    sens[1] <= pwdata[15:0];
          REG_SENS_D:    sens[2] <= pwdata[15:0];
          REG_SENS_E:    sens[3] <= pwdata[15:0];
          REG_SENS_F:    sens[4] <= pwdata[15:0];
          default: ;
        endcase
      end
      if (bin_ch.valid && bin_ch.ready)
        calib_q.push_back(calibrate_bin(bin_ch.channel, bin_ch.bin_index,
                                        bin_ch.re_in, bin_ch.im_in));
      if (res_ch.valid && res_ch.ready) begin
        if (calib_q.size() == 0) begin
          $error("result transfer with no bin outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = calib_q[0];
          calib_q.delete(0);
          if (res_ch.channel_out !== want.channel || res_ch.bin_out !== want.bin ||
              res_ch.re_out !== want.re || res_ch.im_out !== want.im ||
              res_ch.suppressed !== want.supp)
            fail_count <= fail_count + 1;
          if (res_ch.channel_out !== want.channel)
            $error("channel_out expected %0d actual %0d", want.channel, res_ch.channel_out);
          if (res_ch.bin_out !== want.bin)
            $error("bin_out expected %0d actual %0d", want.bin, res_ch.bin_out);
          if (res_ch.re_out !== want.re)
            $error("re_out expected %0d actual %0d", want.re, res_ch.re_out);
          if (res_ch.im_out !== want.im)
            $error("im_out expected %0d actual %0d", want.im, res_ch.im_out);
          if (res_ch.suppressed !== want.supp)
            $error("suppressed expected %0d actual %0d", want.supp, res_ch.suppressed);
        end
      end
      outstanding <= calib_q.size();
    end
  end

endmodule

[test/spectrum_bin_calibration_tb.sv]
// ----------------------------------------------------------------------------
// spectrum_bin_calibration_tb
// Streams directed and random bins through the block under several register
// settings with random gaps and stalls on both channels; the checker module
// predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
module spectrum_bin_calibration_tb;
  import sbc_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE     = 90;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  int          idle_cycles;
  bit          hold_out;
  bit          out_burst;
  bit          in_burst;
  logic [15:0] cur_bw;

  sbc_bin_if bin_ch ();
  sbc_res_if res_ch ();

  spectrum_bin_calibration dut (
    .clk(clk), .rst(rst), .spec_in(bin_ch), .spec_out(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  spectrum_bin_calibration_checker checker_i (
    .clk(clk), .rst(rst), .bin_ch(bin_ch), .res_ch(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (bin_ch.valid && bin_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, bursts without stalls, long hold-offs
  initial begin
    int n;
    res_ch.ready <= 1'b0;
    forever begin
      if (hold_out) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_out = 0;
      end
      n = out_burst ? 0 : $urandom_range(0, 14);
      if (n != 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BIN_WIDTH) cur_bw = value[15:0];
  endtask

  // Hold until every expected result has come, then let the pipe settle
  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_bin(logic [2:0] ch, logic [11:0] idx, logic [23:0] re,
                          logic [23:0] im);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      bin_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bin_ch.valid <= 1'b1;
    bin_ch.channel <= ch;
    bin_ch.bin_index <= idx;
    bin_ch.re_in <= re;
    bin_ch.im_in <= im;
    do @(posedge clk); while (!bin_ch.ready);
  endtask

  function automatic logic [23:0] pick_part();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly bins inside the cutoff, plus DC, top bin and anything at all
  task automatic send_random_bin();
    logic [2:0] ch;
    logic [11:0] idx;
    int lim;
    int r;
    ch = ($urandom_range(0, 19) < 17) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    lim = (cur_bw == 0) ? 4095 : (MAX_FREQ_HZ * 256) / cur_bw;
    if (lim > 4095) lim = 4095;
    if (lim < 1) lim = 1;
    r = $urandom_range(0, 9);
    if (r < 6) idx = 12'($urandom_range(1, lim));
    else if (r == 6) idx = '0;
    else if (r == 7) idx = 12'hFFF;
    else idx = 12'($urandom);
    send_bin(ch, idx, pick_part(), pick_part());
  endtask

  task automatic set_sens(logic [15:0] a, logic [15:0] b, logic [15:0] d,
                          logic [15:0] e, logic [15:0] f);
    write_reg(REG_SENS_A, a);
    write_reg(REG_SENS_B, b);
    write_reg(REG_SENS_D, d);
    write_reg(REG_SENS_E, e);
    write_reg(REG_SENS_F, f);
  endtask

  task automatic run_random(int count, bit mid_pause);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        in_burst = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
      end
      if (mid_pause && i == count / 2) begin
        bin_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      send_random_bin();
    end
    bin_ch.valid <= 1'b0;
    in_burst = 0;
    out_burst = 0;
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    bin_ch.valid <= 1'b0;
    bin_ch.channel <= '0;
    bin_ch.bin_index <= '0;
    bin_ch.re_in <= '0;
    bin_ch.im_in <= '0;
    hold_out = 0;
    out_burst = 0;
    in_burst = 0;
    cur_bw = 16'd256;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: every channel, DC, cutoff edge, top bin, extreme values
    for (int c = 0; c < 8; c++) send_bin(3'(c), 12'd1, 24'h7FFFFF, 24'h800000);
    send_bin(CH_A, 12'd0, 24'h800000, 24'h7FFFFF);
    send_bin(CH_B, 12'd400, 24'h000100, 24'hFFFF00);
    send_bin(CH_A, 12'd401, 24'h123456, 24'h654321);
    send_bin(CH_D, 12'd401, 24'h123456, 24'h800000);
    send_bin(CH_E, 12'hFFF, 24'h7FFFFF, 24'h000001);
    send_bin(CH_F, 12'd399, 24'h800000, 24'h800000);
    send_bin(CH_B, 12'hFFF, 24'hFFFFFF, 24'h000000);
    send_bin(CH_F, 12'd16, 24'h000000, 24'h000000);
    bin_ch.valid <= 1'b0;
    drain();
    run_random(170, 0);

    // Correction off, high threshold, finest spacing, top sensitivity
    write_reg(REG_ENABLE, 32'd0);
    write_reg(REG_THRESH, 32'd1000);
    write_reg(REG_BIN_WIDTH, 32'd1);
    set_sens(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(180, 1);

    // Coarsest spacing, zero sensitivity
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_THRESH, 32'd0);
    write_reg(REG_BIN_WIDTH, 32'hFFFF);
    set_sens(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(150, 0);

    // Zero spacing: all bins at the lowest breakpoint
    write_reg(REG_THRESH, 32'd500);
    write_reg(REG_BIN_WIDTH, 32'd0);
    set_sens(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(150, 0);

    // Full threshold; long hold on the result side fills the block
    write_reg(REG_THRESH, 32'hFFFFFF);
    write_reg(REG_BIN_WIDTH, 32'd2560);
    set_sens(16'hFFFF, 16'd1, 16'd256, 16'hFFFF, 16'd1);
    hold_out = 1;
    run_random(150, 0);

    // Random settings
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_THRESH, $urandom_range(0, 5000));
      write_reg(REG_BIN_WIDTH, $urandom_range(1, 8000));
      set_sens(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
      if (p == 1) hold_out = 1;
      run_random(150, p == 2);
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
